### hdl/pst_pkg.sv
// Shared constants and types for the process slot table.
package pst_pkg;

   localparam int ENTRIES  = 32;
   localparam int IDX_W    = $clog2(ENTRIES);
   localparam int CNT_W    = 7;
   localparam int SLOT_W   = 6;

   typedef enum logic [2:0] {
      OP_ADD      = 3'd0,
      OP_DELETE   = 3'd1,
      OP_FIND_PID = 3'd2,
      OP_FIND_TID = 3'd3,
      OP_FIND_ALL = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_NOTFOUND = 2'd2
   } status_type;

   // handle [31:0], pid [47:32], tid [63:48]
   typedef struct packed {
      logic [15:0] tid;
      logic [15:0] pid;
      logic [31:0] handle;
   } entry_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [SLOT_W-1:0] slot_index;
      logic [31:0]       found_handle;
      logic [CNT_W-1:0]  match_count;
      logic [CNT_W-1:0]  live_count;
      logic              last;
   } result_type;

endpackage

### hdl/pst_ram.sv
// Single-port-write, registered-read entry memory.
module pst_ram
   import pst_pkg::*;
(
   input  logic                clock,
   input  logic                wr_en,
   input  logic [IDX_W-1:0]    wr_addr,
   input  entry_type           wr_data,
   input  logic [IDX_W-1:0]    rd_addr,
   output entry_type           rd_data
);

   entry_type mem [ENTRIES];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### hdl/process_slot_table.sv
// Process slot table: top level with sequencer, valid bits and result register.
//
// Requests enter on req_ (tdata = op, handle, key_pid, key_tid) and results
// leave on rsp_ (tdata = status, slot_index, found_handle, match_count,
// live_count; tlast marks the final result of a request).
// Entry data lives in a one-port-write memory with a registered read;
// valid bits, the high-water mark and the live count are flip-flops.
// One request is handled at a time. A search walks slots 0 up to one below
// the high-water mark, issuing the read of a slot and then comparing its
// data, and stops at the first hit for delete/find. Find-all walks the
// whole range; each hit is held in a pending register until the next hit
// or the end of the range, so the final one can carry tlast. An add writes
// the slot at the mark, after a compaction pass when the mark is at
// capacity (read one slot, write it down to the next free place). The
// sequencer returns to idle for the next request when the last result loads.
// The walk pauses while a result waits in the output register, so a
// stalled receiver only stretches the request; nothing is lost.
// Reset clears valid bits, mark and count; no clearing pass is needed.
module process_slot_table
   import pst_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // op[2:0], handle[34:3], key_pid[50:35], key_tid[66:51]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // status[1:0], slot_index[7:2], found_handle[39:8],
                                    // match_count[46:40], live_count[53:47]
   output logic        rsp_tlast
);

   typedef enum logic [2:0] {
      S_IDLE, S_DECIDE, S_SCAN, S_CMP, S_PACK, S_PACKW, S_ADD
   } state_type;

   state_type            state_ff, state_in;
   logic [2:0]           op_ff, op_in;
   entry_type            key_ff, key_in;
   logic [ENTRIES-1:0]   valid_ff, valid_in;
   logic [CNT_W-1:0]     hw_ff, hw_in, live_ff, live_in, nmatch_ff, nmatch_in;
   logic [CNT_W-1:0]     idx_ff, idx_in, wp_ff, wp_in;
   logic                 rv_ff, rv_in;
   result_type           res_ff, res_in;
   result_type           pend_ff, pend_in;

   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr, rd_addr;
   entry_type            wr_data, rd_data;

   pst_ram u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   logic [IDX_W-1:0] idx_s, cmp_s;
   logic             hit;
   logic             free_out;

   assign idx_s    = idx_ff[IDX_W-1:0];
   assign cmp_s    = idx_s - IDX_W'(1);
   assign free_out = !rv_ff || rsp_tready;

   always_comb begin
      hit = valid_ff[cmp_s];
      unique case (op_ff)
         OP_DELETE:   hit = hit && (rd_data.handle == key_ff.handle);
         OP_FIND_TID: hit = hit && (rd_data.pid == key_ff.pid)
                                && (rd_data.tid == key_ff.tid);
         default:     hit = hit && (rd_data.pid == key_ff.pid);
      endcase
   end

   function automatic result_type mk(input logic [1:0] st, input logic [SLOT_W-1:0] sl,
                                     input logic [31:0] h, input logic [CNT_W-1:0] mc,
                                     input logic [CNT_W-1:0] lc, input logic la);
      result_type r;
      r.status = st; r.slot_index = sl; r.found_handle = h;
      r.match_count = mc; r.live_count = lc; r.last = la;
      return r;
   endfunction

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      key_in    = key_ff;
      valid_in  = valid_ff;
      hw_in     = hw_ff;
      live_in   = live_ff;
      nmatch_in = nmatch_ff;
      idx_in    = idx_ff;
      wp_in     = wp_ff;
      rv_in     = rv_ff && !rsp_tready;
      res_in    = res_ff;
      pend_in   = pend_ff;
      wr_en     = 1'b0;
      wr_addr   = idx_s;
      wr_data   = key_ff;
      rd_addr   = idx_s;
      req_tready = (state_ff == S_IDLE);

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in         = req_tdata[2:0];
               key_in.handle = req_tdata[34:3];
               key_in.pid    = req_tdata[50:35];
               key_in.tid    = req_tdata[66:51];
               idx_in        = '0;
               nmatch_in     = '0;
               wp_in         = '0;
               state_in      = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (free_out) begin
               case (op_ff)
                  OP_ADD: begin
                     if (live_ff >= CNT_W'(ENTRIES)) begin
                        rv_in = 1'b1;
                        res_in = mk(ST_FULL, '0, '0, '0, live_ff, 1'b1);
                        state_in = S_IDLE;
                     end else if (hw_ff >= CNT_W'(ENTRIES)) begin
                        state_in = S_PACK;
                     end else begin
                        state_in = S_ADD;
                     end
                  end
                  OP_DELETE, OP_FIND_PID, OP_FIND_TID, OP_FIND_ALL: begin
                     state_in = S_SCAN;
                  end
                  default: begin
                     rv_in = 1'b1;
                     res_in = mk(ST_NOTFOUND, '0, '0, '0, live_ff, 1'b1);
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         // issue read of slot idx
         S_SCAN: begin
            if (free_out) begin
               if (idx_ff >= hw_ff) begin
                  rv_in = 1'b1;
                  if (nmatch_ff != '0) begin
                     // final find-all hit still pending: send it with tlast
                     res_in = pend_ff;
                     res_in.last = 1'b1;
                  end else begin
                     res_in = mk(ST_NOTFOUND, '0, '0, '0, live_ff, 1'b1);
                  end
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_CMP;
               end
            end
         end
         // rd_data holds slot idx-1
         S_CMP: begin
            if (hit) begin
               if (op_ff == OP_FIND_ALL) begin
                  // emit previous pending hit, hold this one
                  if (nmatch_ff != '0) begin
                     rv_in  = 1'b1;
                     res_in = pend_ff;
                  end
                  nmatch_in = nmatch_ff + 1'b1;
                  pend_in = mk(ST_OK, SLOT_W'(cmp_s), rd_data.handle,
                               nmatch_ff + 1'b1, live_ff, 1'b0);
                  state_in = S_SCAN;
               end else if (op_ff == OP_DELETE) begin
                  valid_in[cmp_s] = 1'b0;
                  live_in = live_ff - 1'b1;
                  rv_in = 1'b1;
                  res_in = mk(ST_OK, SLOT_W'(cmp_s), '0, '0, live_ff - 1'b1, 1'b1);
                  state_in = S_IDLE;
               end else begin
                  rv_in = 1'b1;
                  res_in = mk(ST_OK, SLOT_W'(cmp_s), rd_data.handle, '0, live_ff, 1'b1);
                  state_in = S_IDLE;
               end
            end else begin
               state_in = S_SCAN;
            end
         end
         S_PACK: begin
            if (idx_ff >= hw_ff) begin
               valid_in = '0;
               for (int k = 0; k < ENTRIES; k++) begin
                  valid_in[k] = (CNT_W'(k) < wp_ff);
               end
               hw_in    = wp_ff;
               state_in = S_ADD;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_PACKW;
            end
         end
         S_PACKW: begin
            if (valid_ff[cmp_s]) begin
               wr_en   = 1'b1;
               wr_addr = wp_ff[IDX_W-1:0];
               wr_data = rd_data;
               wp_in   = wp_ff + 1'b1;
            end
            state_in = S_PACK;
         end
         S_ADD: begin
            wr_en   = 1'b1;
            wr_addr = hw_ff[IDX_W-1:0];
            valid_in[hw_ff[IDX_W-1:0]] = 1'b1;
            hw_in   = hw_ff + 1'b1;
            live_in = live_ff + 1'b1;
            rv_in   = 1'b1;
            res_in  = mk(ST_OK, SLOT_W'(hw_ff), '0, '0, live_ff + 1'b1, 1'b1);
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
         hw_ff    <= '0;
         live_ff  <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         hw_ff    <= hw_in;
         live_ff  <= live_in;
         rv_ff    <= rv_in;
      end
      op_ff     <= op_in;
      key_ff    <= key_in;
      nmatch_ff <= nmatch_in;
      idx_ff    <= idx_in;
      wp_ff     <= wp_in;
      res_ff    <= res_in;
      pend_ff   <= pend_in;
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tlast  = res_ff.last;
   assign rsp_tdata  = {2'b00, res_ff.live_count, res_ff.match_count,
                        res_ff.found_handle, res_ff.slot_index, res_ff.status};

endmodule

### hdl/pst_checker.sv
// Port-level checks for the process slot table, bound to the top level.
module pst_checker
   import pst_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [71:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic        rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_live_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[53:47] <= 7'(ENTRIES))
      else $error("live count above capacity");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] != 2'd0 |-> rsp_tdata[46:2] == '0 && rsp_tlast)
      else $error("failed result carries data");

   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

endmodule

bind process_slot_table pst_checker u_pst_checker (.*);
